### rtl/core/apl_pkg.sv
`default_nettype none

package apl_pkg;

   // result kinds
   localparam logic [1:0] KIND_TX     = 2'd0;
   localparam logic [1:0] KIND_ALARM  = 2'd1;
   localparam logic [1:0] KIND_NOTICE = 2'd2;
   localparam logic [1:0] KIND_CMD    = 2'd3;

   localparam logic [15:0] CRC_POLY      = 16'h1021;
   localparam logic [7:0]  SYNC0         = 8'hA5;
   localparam logic [7:0]  SYNC1         = 8'h53;
   localparam logic [7:0]  TYPE_ADDRESSED = 8'h1A;
   localparam logic [7:0]  TYPE_BROADCAST = 8'h1B;
   localparam logic [7:0]  TYPE_REPLY    = 8'h1C;
   localparam logic [7:0]  RESYNC_CODE   = 8'hE2;
   localparam logic [7:0]  BROADCAST_ADDR = 8'hFF;
   localparam logic [7:0]  STATION_RESET = 8'h0A;
   localparam logic [7:0]  CODE_RESYNC   = 8'd3;
   localparam logic [7:0]  ALARM_LO      = 8'd16;
   localparam logic [7:0]  ALARM_HI      = 8'd20;
   localparam logic [7:0]  FIELD_BASE    = 8'd10;
   localparam logic [7:0]  VALUE_POS     = 8'd21;
   localparam logic [7:0]  POS_MAX       = 8'hFF;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one unit of work handed from the front to the back
   typedef struct packed {
      logic [1:0]      kind;
      logic            alarm;
      logic [7:0]      code;
      logic [5:0][7:0] fields;
      logic [7:0]      dest;
      logic [7:0]      station;
      logic [7:0]      reply_code;
      logic [7:0]      tail;
      logic            accepted;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] tx_byte;
      logic       last;
      logic [7:0] event_code;
      logic [7:0] panel;
      logic [7:0] loop_number;
      logic [7:0] zone;
      logic [7:0] element;
      logic [7:0] element_type;
      logic [7:0] value;
      logic       cmd_accepted;
   } rsp_type;

   // CRC-16/XMODEM, one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### rtl/core/apl_if.sv
`default_nettype none

interface apl_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] rx_byte;
   logic [2:0] cmd;
   modport source (output valid, func, rx_byte, cmd, input ready);
   modport sink (input valid, func, rx_byte, cmd, output ready);
endinterface

interface apl_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] tx_byte;
   logic       last;
   logic [7:0] event_code;
   logic [7:0] panel;
   logic [7:0] loop_number;
   logic [7:0] zone;
   logic [7:0] element;
   logic [7:0] element_type;
   logic [7:0] value;
   logic       cmd_accepted;
   modport source (output valid, kind, tx_byte, last, event_code, panel, loop_number, zone,
                   element, element_type, value, cmd_accepted, input ready);
   modport sink (input valid, kind, tx_byte, last, event_code, panel, loop_number, zone,
                 element, element_type, value, cmd_accepted, output ready);
endinterface

interface apl_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

### rtl/core/apl_front.sv
`default_nettype none

module apl_front #(
   parameter int unsigned NUM_COMMANDS = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   apl_req_if.sink               req,
   apl_csr_if.sink               csr,
   input  apl_pkg::q_status_type q_stat,
   output logic                  push,
   output apl_pkg::job_type      push_job
);
   import apl_pkg::*;

   logic [7:0]              station_ff;
   logic [7:0]              hs_ff [8];
   logic [7:0]              hs_in [8];
   logic [7:0]              crc_low_ff, crc_low_in;
   logic [15:0]             run_crc_ff, run_crc_in;
   logic [7:0]              pos_ff, pos_in;
   logic [7:0]              ext_ff, ext_in;
   logic [5:0][7:0]         fields_ff, fields_in;
   logic [NUM_COMMANDS-1:0] pend_ff, pend_in;
   logic                    phase_ff, phase_in;

   logic       accept;
   logic       finish;
   logic       ok;
   logic       accepted;
   logic       addressed;
   logic       broadcast;
   logic       resync;
   logic [7:0] sel;
   logic [7:0] code;

   assign accept    = req.valid && req.ready;
   assign req.ready = !q_stat.full;
   assign csr.ready = 1'b1;
   assign code      = hs_ff[6];

   always_comb begin
      hs_in      = hs_ff;
      crc_low_in = crc_low_ff;
      run_crc_in = run_crc_ff;
      pos_in     = pos_ff;
      ext_in     = ext_ff;
      fields_in  = fields_ff;
      pend_in    = pend_ff;
      phase_in   = phase_ff;
      finish     = 1'b0;
      push       = 1'b0;
      push_job   = '0;
      ok         = hs_ff[0] == SYNC0 && hs_ff[1] == SYNC1 &&
                   {req.rx_byte, crc_low_ff} == run_crc_ff;
      accepted   = req.cmd != 3'd0 && 32'(req.cmd) < NUM_COMMANDS;
      addressed  = hs_ff[2] == station_ff && hs_ff[5] == TYPE_ADDRESSED;
      broadcast  = hs_ff[2] == BROADCAST_ADDR && hs_ff[5] == TYPE_BROADCAST;
      resync     = pend_ff[0] || code == CODE_RESYNC;

      sel = 8'd0;
      for (int i = NUM_COMMANDS - 1; i >= 1; i--) begin
         if (pend_ff[i]) begin
            sel = 8'(i);
         end
      end

      if (accept) begin
         if (req.func) begin
            push          = 1'b1;
            push_job.kind = KIND_CMD;
            push_job.accepted = accepted;
            for (int i = 1; i < NUM_COMMANDS; i++) begin
               if (accepted && 32'(req.cmd) == i) begin
                  pend_in[i] = 1'b1;
               end
            end
         end else if (phase_ff) begin
            // extension bytes: keep the offsets of interest
            for (int i = 0; i < 5; i++) begin
               if (pos_ff == FIELD_BASE + 8'(i)) begin
                  fields_in[i] = req.rx_byte;
               end
            end
            if (pos_ff == VALUE_POS) begin
               fields_in[5] = req.rx_byte;
            end
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + 8'd1;
            end
            if (ext_ff != 8'd0) begin
               ext_in = ext_ff - 8'd1;
            end
            if (ext_in == 8'd0) begin
               phase_in = 1'b0;
               pos_in   = 8'd0;
               finish   = 1'b1;
            end
         end else if (pos_ff < 8'd8) begin
            hs_in[pos_ff[2:0]] = req.rx_byte;
            run_crc_in         = crc_byte(run_crc_ff, req.rx_byte);
            pos_in             = pos_ff + 8'd1;
         end else if (pos_ff == 8'd8) begin
            crc_low_in = req.rx_byte;
            pos_in     = 8'd9;
         end else begin
            run_crc_in = 16'd0;
            pos_in     = 8'd0;
            if (ok) begin
               ext_in = hs_ff[4];
               if (hs_ff[4] == 8'd0) begin
                  finish = 1'b1;
               end else begin
                  phase_in = 1'b1;
                  pos_in   = FIELD_BASE;
               end
            end
         end
      end

      if (finish) begin
         if (addressed) begin
            push            = 1'b1;
            push_job.kind   = KIND_TX;
            push_job.alarm  = code inside {[ALARM_LO:ALARM_HI]};
            push_job.code   = code;
            push_job.fields = fields_in;
            push_job.dest   = hs_ff[3];
            push_job.station = station_ff;
            push_job.tail   = hs_ff[7];
            if (resync) begin
               pend_in[0]          = 1'b0;
               push_job.reply_code = RESYNC_CODE;
            end else begin
               push_job.reply_code = sel;
               for (int i = 1; i < NUM_COMMANDS; i++) begin
                  if (sel == 8'(i)) begin
                     pend_in[i] = 1'b0;
                  end
               end
            end
         end else if (broadcast) begin
            push          = 1'b1;
            push_job.kind = KIND_NOTICE;
            push_job.code = code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         station_ff <= STATION_RESET;
         crc_low_ff <= 8'd0;
         run_crc_ff <= 16'd0;
         pos_ff     <= 8'd0;
         ext_ff     <= 8'd0;
         pend_ff    <= '0;
         phase_ff   <= 1'b0;
      end else begin
         if (csr.valid && csr.ready) begin
            station_ff <= csr.data;
         end
         crc_low_ff <= crc_low_in;
         run_crc_ff <= run_crc_in;
         pos_ff     <= pos_in;
         ext_ff     <= ext_in;
         pend_ff    <= pend_in;
         phase_ff   <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      hs_ff     <= hs_in;
      fields_ff <= fields_in;
   end

endmodule

`default_nettype wire

### rtl/core/apl_job_queue.sv
`default_nettype none

module apl_job_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  apl_pkg::job_type      push_job,
   input  logic                  pop,
   output apl_pkg::job_type      head_job,
   output apl_pkg::q_status_type q_stat
);
   import apl_pkg::*;

   job_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   assign head_job     = mem_ff[rd_ff];
   assign q_stat.full  = cnt_ff == QCNT_W'(QUEUE_DEPTH);
   assign q_stat.empty = cnt_ff == '0;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

### rtl/core/apl_back.sv
`default_nettype none

module apl_back (
   input  logic                  clock,
   input  logic                  reset,
   input  apl_pkg::job_type      head_job,
   input  apl_pkg::q_status_type q_stat,
   output logic                  pop,
   apl_rsp_if.source             rsp
);
   import apl_pkg::*;

   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  idx_ff, idx_in;
   logic        alarm_done_ff, alarm_done_in;
   logic [15:0] crc_ff, crc_in;

   logic       adv;
   logic       fire;
   logic [7:0] b;

   assign adv  = !rsp_valid_ff || rsp.ready;
   assign fire = adv && !q_stat.empty;

   always_comb begin
      case (idx_ff)
         4'd0:    b = SYNC0;
         4'd1:    b = SYNC1;
         4'd2:    b = head_job.dest;
         4'd3:    b = head_job.station;
         4'd4:    b = 8'h00;
         4'd5:    b = TYPE_REPLY;
         4'd6:    b = head_job.reply_code;
         4'd7:    b = head_job.tail;
         4'd8:    b = crc_ff[7:0];
         4'd9:    b = crc_ff[15:8];
         default: b = 8'h00;
      endcase
   end

   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      idx_in        = idx_ff;
      alarm_done_in = alarm_done_ff;
      crc_in        = crc_ff;
      pop           = 1'b0;
      if (adv) begin
         rsp_valid_in = fire;
      end
      if (fire) begin
         rsp_in      = '0;
         rsp_in.kind = head_job.kind;
         if (head_job.kind == KIND_CMD) begin
            rsp_in.last         = 1'b1;
            rsp_in.cmd_accepted = head_job.accepted;
            pop                 = 1'b1;
         end else if (head_job.kind == KIND_NOTICE) begin
            rsp_in.last       = 1'b1;
            rsp_in.event_code = head_job.code;
            pop               = 1'b1;
         end else if (head_job.alarm && !alarm_done_ff) begin
            rsp_in.kind         = KIND_ALARM;
            rsp_in.event_code   = head_job.code;
            rsp_in.panel        = head_job.fields[0];
            rsp_in.loop_number  = head_job.fields[1];
            rsp_in.zone         = head_job.fields[2];
            rsp_in.element      = head_job.fields[3];
            rsp_in.element_type = head_job.fields[4];
            rsp_in.value        = head_job.fields[5];
            alarm_done_in       = 1'b1;
         end else begin
            rsp_in.kind    = KIND_TX;
            rsp_in.tx_byte = b;
            if (idx_ff < 4'd8) begin
               crc_in = crc_byte(crc_ff, b);
            end
            if (idx_ff == 4'd9) begin
               rsp_in.last   = 1'b1;
               pop           = 1'b1;
               idx_in        = 4'd0;
               alarm_done_in = 1'b0;
               crc_in        = 16'd0;
            end else begin
               idx_in = idx_ff + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         idx_ff        <= 4'd0;
         alarm_done_ff <= 1'b0;
         crc_ff        <= 16'd0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         idx_ff        <= idx_in;
         alarm_done_ff <= alarm_done_in;
         crc_ff        <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.kind         = rsp_ff.kind;
   assign rsp.tx_byte      = rsp_ff.tx_byte;
   assign rsp.last         = rsp_ff.last;
   assign rsp.event_code   = rsp_ff.event_code;
   assign rsp.panel        = rsp_ff.panel;
   assign rsp.loop_number  = rsp_ff.loop_number;
   assign rsp.zone         = rsp_ff.zone;
   assign rsp.element      = rsp_ff.element;
   assign rsp.element_type = rsp_ff.element_type;
   assign rsp.value        = rsp_ff.value;
   assign rsp.cmd_accepted = rsp_ff.cmd_accepted;

endmodule

`default_nettype wire

### rtl/core/alarm_panel_link_responder.sv
// Throughput: the front takes one word per cycle unless the job queue is full; results of a
//   word pass through the queue and the back's output register. The back sends one result per
//   cycle while rsp_bus is ready: 10 for a replied frame (11 with an alarm report), else one.
// A 4-entry job queue between them sets how far the front runs ahead of a stalled back.
// Reset: synchronous, active high; clears parser, pending commands, queue and output valid,
//   and loads the station address with 0x0A. Ready from the first cycle after reset drops.
`default_nettype none

module alarm_panel_link_responder #(
   parameter int unsigned NUM_COMMANDS = 6
) (
   input  logic      clock,
   input  logic      reset,
   apl_req_if.sink   req_bus,
   apl_rsp_if.source rsp_bus,
   apl_csr_if.sink   csr_bus
);
   import apl_pkg::*;

   // front to queue
   logic         q_push;
   job_type      q_push_job;
   // queue to back
   logic         q_pop;
   job_type      q_head_job;
   q_status_type q_stat;

   // Front: parse the byte stream, check sync and CRC, walk the extension and
   // decide the reply code at the end of each frame. Command requests update
   // the pending flags here, so their order against frames is kept exactly.
   apl_front #(
      .NUM_COMMANDS(NUM_COMMANDS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .csr      (csr_bus),
      .q_stat   (q_stat),
      .push     (q_push),
      .push_job (q_push_job)
   );

   // Queue: hold finished jobs while the back drains a reply burst.
   apl_job_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .pop      (q_pop),
      .head_job (q_head_job),
      .q_stat   (q_stat)
   );

   // Back: expand each job into its result words, computing the reply CRC
   // one byte per cycle as the reply goes out, unless rsp_bus stalls it.
   apl_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (q_head_job),
      .q_stat   (q_stat),
      .pop      (q_pop),
      .rsp      (rsp_bus)
   );

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("job pushed into a full queue");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !req_bus.ready)
      else $error("input ready while job queue is full");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.kind == KIND_CMD || rsp_bus.kind == KIND_NOTICE)
      |-> rsp_bus.last)
      else $error("single-result word without last");

   a_alarm_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.kind == KIND_ALARM |-> !rsp_bus.last)
      else $error("alarm report marked last");
`endif

endmodule

`default_nettype wire

### dv/tb_top.sv
`default_nettype none

module tb_top;
   import apl_pkg::*;

   localparam int NUM_CMDS = 6;
   // extension bytes needed to reach the value field at offset 21
   localparam int FULL_EXT = VALUE_POS - FIELD_BASE + 1;
   localparam int PHASES   = 5;
   localparam int PHASE_WORDS = 46;

   typedef enum int {FLAW_NONE, FLAW_CRC, FLAW_SYNC, FLAW_CUT} flaw_type;

   // Shadow of the responder: parser, captured fields, pending commands and the station
   // address, plus the queue of results still owed by the block.
   class link_scoreboard #(int NCMD = 6);
      rsp_type     owed_q[$];
      rsp_type     word_q[$];
      logic [7:0]  station;
      logic [7:0]  hdr[8];
      logic [7:0]  crc_low;
      logic [15:0] crc_acc;
      logic [7:0]  pos;
      logic [7:0]  ext_left;
      bit          in_ext;
      logic [7:0]  cap[6];
      logic [5:0]  cap_seen;
      bit          flags[NCMD];
      int          errors;
      int          seen;
      int          alarms;
      int          notices;
      int          replies;

      function new();
         station  = STATION_RESET;
         crc_low  = '0;
         crc_acc  = '0;
         pos      = '0;
         ext_left = '0;
         in_ext   = 0;
         cap_seen = '0;
         foreach (hdr[i]) hdr[i] = '0;
         foreach (cap[i]) cap[i] = '0;
         foreach (flags[i]) flags[i] = 0;
         errors = 0;
         seen = 0;
         alarms = 0;
         notices = 0;
         replies = 0;
      endfunction

      // bit-serial form of the XMODEM polynomial
      static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
         logic [15:0] c;
         logic        fb;
         c = crc;
         for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0};
            if (fb) c = c ^ CRC_POLY;
         end
         return c;
      endfunction

      function rsp_type blank(logic [1:0] k);
         rsp_type r;
         r = '0;
         r.kind = k;
         return r;
      endfunction

      function void close_frame();
         rsp_type     r;
         logic [7:0]  code;
         logic [7:0]  rep[10];
         logic [15:0] c;
         code = hdr[6];
         if (hdr[2] == station && hdr[5] == TYPE_ADDRESSED) begin
            if (code == CODE_RESYNC) flags[0] = 1;
            if (code >= ALARM_LO && code <= ALARM_HI) begin
               r = blank(KIND_ALARM);
               r.event_code   = code;
               r.panel        = cap[0];
               r.loop_number  = cap[1];
               r.zone         = cap[2];
               r.element      = cap[3];
               r.element_type = cap[4];
               r.value        = cap[5];
               word_q.push_back(r);
               alarms++;
            end
            rep[6] = 8'h00;
            if (flags[0]) begin
               flags[0] = 0;
               rep[6] = RESYNC_CODE;
            end else begin
               for (int i = 1; i < NCMD; i++) begin
                  if (flags[i]) begin
                     rep[6] = 8'(i);
                     flags[i] = 0;
                     break;
                  end
               end
            end
            rep[0] = hdr[0];
            rep[1] = hdr[1];
            rep[2] = hdr[3];
            rep[3] = station;
            rep[4] = 8'h00;
            rep[5] = TYPE_REPLY;
            rep[7] = hdr[7];
            c = '0;
            for (int i = 0; i < 8; i++) c = crc_step(c, rep[i]);
            rep[8] = c[7:0];
            rep[9] = c[15:8];
            for (int i = 0; i < 10; i++) begin
               r = blank(KIND_TX);
               r.tx_byte = rep[i];
               word_q.push_back(r);
            end
            replies++;
         end else if (hdr[2] == BROADCAST_ADDR && hdr[5] == TYPE_BROADCAST) begin
            r = blank(KIND_NOTICE);
            r.event_code = code;
            word_q.push_back(r);
            notices++;
         end
      endfunction

      function void take_rx(logic [7:0] b);
         bit ok;
         if (in_ext) begin
            if (pos >= FIELD_BASE && pos < FIELD_BASE + 5) begin
               cap[pos - FIELD_BASE] = b;
               cap_seen[pos - FIELD_BASE] = 1'b1;
            end else if (pos == VALUE_POS) begin
               cap[5] = b;
               cap_seen[5] = 1'b1;
            end
            if (pos != POS_MAX) pos++;
            if (ext_left != 0) ext_left--;
            if (ext_left == 0) begin
               in_ext = 0;
               pos = '0;
               close_frame();
            end
         end else if (pos < 8) begin
            hdr[pos[2:0]] = b;
            crc_acc = crc_step(crc_acc, b);
            pos++;
         end else if (pos == 8) begin
            crc_low = b;
            pos = 8'd9;
         end else begin
            ok = hdr[0] == SYNC0 && hdr[1] == SYNC1 && {b, crc_low} == crc_acc;
            crc_acc = '0;
            pos = '0;
            if (ok) begin
               ext_left = hdr[4];
               if (ext_left == 0) begin
                  close_frame();
               end else begin
                  in_ext = 1;
                  pos = FIELD_BASE;
               end
            end
         end
      endfunction

      function void note_word(logic f, logic [7:0] b, logic [2:0] c);
         rsp_type r;
         word_q.delete();
         if (f) begin
            r = blank(KIND_CMD);
            if (c != 0 && c < NCMD) begin
               flags[c] = 1;
               r.cmd_accepted = 1'b1;
            end
            word_q.push_back(r);
         end else begin
            take_rx(b);
         end
         if (word_q.size() > 0) begin
            r = word_q.pop_back();
            r.last = 1'b1;
            word_q.push_back(r);
         end
         foreach (word_q[i]) owed_q.push_back(word_q[i]);
      endfunction

      // pick a filler byte that can never complete a valid header
      function logic [7:0] harmless(logic [7:0] b);
         if (!in_ext && pos == 9 && hdr[0] == SYNC0 && hdr[1] == SYNC1 &&
             {b, crc_low} == crc_acc) return b ^ 8'h01;
         return b;
      endfunction

      function bit at_start();
         return !in_ext && pos == 0;
      endfunction

      function int outstanding();
         return owed_q.size();
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 100) $display("MISMATCH: %s", msg);
      endtask

      task check_result(rsp_type got);
         rsp_type w;
         string   diff;
         seen++;
         if (owed_q.size() == 0) begin
            report($sformatf("result %0d arrived with nothing owed (kind %0d)", seen, got.kind));
            return;
         end
         w = owed_q.pop_front();
         diff = "";
         if (got.kind !== w.kind) diff = {diff, " kind"};
         if (got.tx_byte !== w.tx_byte) diff = {diff, " tx_byte"};
         if (got.last !== w.last) diff = {diff, " last"};
         if (got.event_code !== w.event_code) diff = {diff, " event_code"};
         if (got.panel !== w.panel) diff = {diff, " panel"};
         if (got.loop_number !== w.loop_number) diff = {diff, " loop_number"};
         if (got.zone !== w.zone) diff = {diff, " zone"};
         if (got.element !== w.element) diff = {diff, " element"};
         if (got.element_type !== w.element_type) diff = {diff, " element_type"};
         if (got.value !== w.value) diff = {diff, " value"};
         if (got.cmd_accepted !== w.cmd_accepted) diff = {diff, " cmd_accepted"};
         if (diff != "")
            report($sformatf("result %0d differs in%s: got %h want %h", seen, diff, got, w));
      endtask
   endclass

   logic clock;
   logic reset;

   apl_req_if req_bus ();
   apl_rsp_if rsp_bus ();
   apl_csr_if csr_bus ();

   alarm_panel_link_responder #(
      .NUM_COMMANDS(NUM_CMDS)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   link_scoreboard #(NUM_CMDS) sb;

   // odds of an idle burst on either side; zero means no idling at all
   int idle_odds;
   int stall_left;
   int words_sent;
   int cmds_sent;
   int frames_sent;
   int bad_frames;
   int csr_writes;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Hard stop: far beyond the slowest legal run.
   initial begin
      #5000000;
      $display("tb_top: errors");
      $finish;
   end

   // Receiver side: hold ready low in random bursts, never inside quiet stretches.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds * 2) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Take every accepted result at the rising edge and hand it to the scoreboard.
   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.kind         = rsp_bus.kind;
         got.tx_byte      = rsp_bus.tx_byte;
         got.last         = rsp_bus.last;
         got.event_code   = rsp_bus.event_code;
         got.panel        = rsp_bus.panel;
         got.loop_number  = rsp_bus.loop_number;
         got.zone         = rsp_bus.zone;
         got.element      = rsp_bus.element;
         got.element_type = rsp_bus.element_type;
         got.value        = rsp_bus.value;
         got.cmd_accepted = rsp_bus.cmd_accepted;
         sb.check_result(got);
      end
   end

   // Drive one word. Enter and leave at a falling edge; note the word in the
   // scoreboard right at the edge where it is taken.
   task automatic send_word(logic f, logic [7:0] b, logic [2:0] c);
      if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.func    <= f;
      req_bus.rx_byte <= b;
      req_bus.cmd     <= c;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_word(f, b, c);
      words_sent++;
      if (f) cmds_sent++;
      @(negedge clock);
   endtask

   // Command request with random junk in the unused byte field.
   task automatic send_cmd(logic [2:0] c);
      send_word(1'b1, 8'($urandom_range(0, 255)), c);
   endtask

   // Mostly legal command numbers, now and then the refused ones.
   task automatic maybe_cmd();
      if ($urandom_range(0, 11) == 0) begin
         if ($urandom_range(0, 3) == 0) send_cmd(3'($urandom_range(0, 7)));
         else send_cmd(3'($urandom_range(1, NUM_CMDS - 1)));
      end
   endtask

   // Feed filler until the parser is back at the start of a header.
   task automatic realign();
      while (!sb.at_start())
         send_word(1'b0, sb.harmless(8'($urandom_range(0, 255))), 3'($urandom_range(0, 7)));
   endtask

   // Build a frame, optionally break it, send it with commands mixed in, then realign.
   task automatic send_frame(logic [7:0] addr, logic [7:0] typ, logic [7:0] code,
                             logic [7:0] ext, flaw_type flaw);
      logic [7:0]  fb[10];
      logic [15:0] c;
      int          n;
      // an alarm report reads every captured field, so make sure all were written once
      if (flaw == FLAW_NONE && code >= ALARM_LO && code <= ALARM_HI &&
          sb.cap_seen != 6'h3F && ext < FULL_EXT)
         ext = 8'(FULL_EXT + $urandom_range(0, 4));
      fb[0] = SYNC0;
      fb[1] = SYNC1;
      fb[2] = addr;
      fb[3] = 8'($urandom_range(0, 255));
      fb[4] = ext;
      fb[5] = typ;
      fb[6] = code;
      fb[7] = 8'($urandom_range(0, 255));
      if (flaw == FLAW_SYNC) begin
         n = $urandom_range(0, 1);
         fb[n] = fb[n] ^ (8'h01 << $urandom_range(0, 7));
      end
      c = '0;
      for (int i = 0; i < 8; i++) c = sb.crc_step(c, fb[i]);
      fb[8] = c[7:0];
      fb[9] = c[15:8];
      if (flaw == FLAW_CRC) begin
         n = 8 + $urandom_range(0, 1);
         fb[n] = fb[n] ^ (8'h01 << $urandom_range(0, 7));
      end
      n = (flaw == FLAW_CUT) ? $urandom_range(1, 9) : 10;
      for (int i = 0; i < n; i++) begin
         maybe_cmd();
         send_word(1'b0, fb[i], 3'($urandom_range(0, 7)));
      end
      if (flaw == FLAW_NONE) begin
         for (int i = 0; i < ext; i++) begin
            maybe_cmd();
            send_word(1'b0, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
         end
      end else begin
         bad_frames++;
      end
      frames_sent++;
      realign();
   endtask

   // Drop valid and hold the sender until every owed result is in, then let the
   // pipeline settle.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_station(logic [7:0] v);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= v;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      sb.station = v;
      csr_writes++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_code();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return CODE_RESYNC;
      if (r < 6) return 8'($urandom_range(ALARM_LO, ALARM_HI));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] pick_ext();
      if ($urandom_range(0, 5) == 0) return 8'($urandom_range(FULL_EXT, 24));
      return 8'($urandom_range(0, FULL_EXT - 1));
   endfunction

   // One random slice: mostly well-formed frames, the rest commands, broken
   // frames and line noise.
   task automatic random_unit();
      int         sel;
      logic [7:0] typ;
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
         send_frame(sb.station, TYPE_ADDRESSED, pick_code(), pick_ext(), FLAW_NONE);
      end else if (sel < 60) begin
         send_frame(BROADCAST_ADDR, TYPE_BROADCAST, 8'($urandom_range(0, 255)), pick_ext(),
                    FLAW_NONE);
      end else if (sel < 67) begin
         case ($urandom_range(0, 2))
            0: typ = TYPE_ADDRESSED;
            1: typ = TYPE_BROADCAST;
            default: typ = 8'($urandom_range(0, 255));
         endcase
         send_frame($urandom_range(0, 1) ? sb.station : 8'($urandom_range(0, 255)), typ,
                    pick_code(), pick_ext(), FLAW_NONE);
      end else if (sel < 78) begin
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 3) == 0) send_cmd(3'($urandom_range(0, 7)));
            else send_cmd(3'($urandom_range(1, NUM_CMDS - 1)));
         end
      end else if (sel < 85) begin
         send_frame(sb.station, TYPE_ADDRESSED, pick_code(), pick_ext(), FLAW_CRC);
      end else if (sel < 90) begin
         send_frame(sb.station, TYPE_ADDRESSED, pick_code(), pick_ext(), FLAW_SYNC);
      end else if (sel < 95) begin
         send_frame(sb.station, TYPE_ADDRESSED, pick_code(), pick_ext(), FLAW_CUT);
      end else begin
         repeat ($urandom_range(1, 12))
            send_word(1'b0, sb.harmless(8'($urandom_range(0, 255))), 3'($urandom_range(0, 7)));
         realign();
      end
   endtask

   initial begin
      int start_words;
      int k;
      sb = new();
      idle_odds   = 3;
      stall_left  = 0;
      words_sent  = 0;
      cmds_sent   = 0;
      frames_sent = 0;
      bad_frames  = 0;
      csr_writes  = 0;
      // drive every input to a known value from time zero
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.func    = 1'b0;
      req_bus.rx_byte = 8'h00;
      req_bus.cmd     = 3'd0;
      csr_bus.valid   = 1'b0;
      csr_bus.data    = 8'h00;
      rsp_bus.ready   = 1'b0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed: commands 0, 7, 6, 1 and 5, a resync request answered with the resync
      // code, then a broadcast notice. The next reply without a resync carries command 1.
      send_cmd(3'd0);
      send_cmd(3'd7);
      send_cmd(3'd6);
      send_cmd(3'd1);
      send_cmd(3'd5);
      send_frame(sb.station, TYPE_ADDRESSED, CODE_RESYNC, 8'd0, FLAW_NONE);
      send_frame(BROADCAST_ADDR, TYPE_BROADCAST, 8'hFF, 8'd0, FLAW_NONE);
      drain();

      // Random phases. Phase 0 runs on the reset address; the others rewrite it
      // while the block is idle. Phase 2 is a quiet stretch, the last one too.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            1: write_station(BROADCAST_ADDR);
            2: write_station(8'h00);
            3: write_station(8'($urandom_range(1, 254)));
            4: write_station(8'($urandom_range(0, 255)));
            default: ;
         endcase
         idle_odds = (p == 2 || p == PHASES - 1) ? 0 : 3 + p;
         start_words = words_sent;
         while (words_sent - start_words < PHASE_WORDS) random_unit();
         drain();
      end

      req_bus.valid <= 1'b0;
      // wait out whatever is still owed, bounded
      k = 0;
      while (sb.outstanding() != 0 && k < 20000) begin
         @(posedge clock);
         k++;
      end
      repeat (16) @(posedge clock);
      if (sb.outstanding() != 0)
         sb.report($sformatf("%0d results never arrived", sb.outstanding()));

      $display("tb_top: %0d words sent (%0d frames, %0d broken, %0d commands), %0d results seen",
               words_sent, frames_sent, bad_frames, cmds_sent, sb.seen);
      $display("tb_top: %0d replies, %0d alarm reports, %0d notices, %0d station writes",
               sb.replies, sb.alarms, sb.notices, csr_writes);
      if (sb.errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
rtl/core/apl_pkg.sv
rtl/core/apl_if.sv
rtl/core/apl_front.sv
rtl/core/apl_job_queue.sv
rtl/core/apl_back.sv
rtl/core/alarm_panel_link_responder.sv
dv/tb_top.sv
